[src/heightmap_to_normal_map_top_defines.svh]
// ----------------------------------------------------------------------------
// Height map to normal map: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_TO_NORMAL_MAP_TOP_DEFINES_SVH
`define HEIGHTMAP_TO_NORMAL_MAP_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HTN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HTN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/htn_pkg.sv]
// ----------------------------------------------------------------------------
// Height map to normal map: package
// Item types, state encodings and fixed constants of the block.
// ----------------------------------------------------------------------------
package htn_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SCALE_W   = 32;
  localparam int IMG_W_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 48;
  localparam int SUM_W     = 64;
  localparam int NUM_W     = 41;
  localparam int DSH_W     = 40;
  localparam int ROOT_W    = 32;
  localparam int NORM_BITS = 30;
  localparam int CODE_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_SCALE = 2'd2;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET    = 13'd4096;
  localparam logic [SCALE_W-1:0] VERTICAL_SCALE_RESET = 32'd16777216;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
    logic [SCALE_W-1:0]  row_x_scale;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
    logic              end_of_row;
    logic              end_of_image;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dx_mag;
    logic                dx_neg;
    logic [SAMPLE_W-1:0] dy_mag;
    logic                dy_neg;
    logic [SCALE_W-1:0]  x_scale;
  } norm_req_t;

  typedef enum logic [2:0] {
    T_IDLE, T_RD_A, T_RD_B, T_RD_C, T_START, T_CALC, T_PUSH
  } top_state_t;

  typedef enum logic [3:0] {
    N_IDLE, N_MX, N_MY, N_GY, N_MAX, N_SHIFT, N_SQX, N_SQY, N_SQZ, N_SUM,
    N_SQRT, N_LOAD, N_DIV, N_DONE
  } norm_state_t;

endpackage

[src/htn_norm.sv]
// ----------------------------------------------------------------------------
// Height map to normal map: normalizer
// Scales the gradient, normalizes (dx, dy, 1) with one shared multiplier,
// a bit-serial square root and a restoring divider, and encodes the codes.
// ----------------------------------------------------------------------------
module htn_norm #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  htn_pkg::norm_req_t                req,
  input  logic [htn_pkg::SCALE_W-1:0]       vscale,
  output logic                              done,
  output logic [htn_pkg::CODE_W-1:0]        red,
  output logic [htn_pkg::CODE_W-1:0]        green,
  output logic [htn_pkg::CODE_W-1:0]        blue
);

  localparam int GW = htn_pkg::PROD_W;
  localparam int NB = htn_pkg::NORM_BITS;
  localparam logic [GW-1:0] GZ_INIT = {{(GW-1){1'b0}}, 1'b1} << SCALE_FRAC_BITS;

  htn_pkg::norm_state_t state_r, state_nxt;
  htn_pkg::norm_req_t   req_r;

  logic [htn_pkg::SUM_W-1:0]  prod_r, sum_r, res_r;
  logic [GW-1:0]              gx_r, gy_r, gz_r, m_r;
  logic [4:0]                 k_r;
  logic [htn_pkg::NUM_W-1:0]  rem_r;
  logic [htn_pkg::DSH_W-1:0]  dsh_r;
  logic [htn_pkg::CODE_W-1:0] q_r, red_r, green_r, blue_r;
  logic [2:0]                 cnt_r;
  logic [1:0]                 ch_r;

  logic [31:0]                mul_a, mul_b;
  logic [htn_pkg::SUM_W-1:0]  sq_bit, sq_try;
  logic [GW-1:0]              m_xy;
  logic [htn_pkg::ROOT_W-1:0] r_eff;
  logic [NB-1:0]              ch_mag;
  logic                       ch_neg;
  logic [htn_pkg::NUM_W-1:0]  r_ext, a_ext, base, gain, num;
  logic                       div_ge;
  logic [htn_pkg::CODE_W-1:0] q_new;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      htn_pkg::N_MX: begin
        mul_a = 32'(req_r.dx_mag);
        mul_b = req_r.x_scale;
      end
      htn_pkg::N_MY: begin
        mul_a = 32'(req_r.dy_mag);
        mul_b = vscale;
      end
      htn_pkg::N_SQX: begin
        mul_a = gx_r[31:0];
        mul_b = gx_r[31:0];
      end
      htn_pkg::N_SQY: begin
        mul_a = gy_r[31:0];
        mul_b = gy_r[31:0];
      end
      htn_pkg::N_SQZ: begin
        mul_a = gz_r[31:0];
        mul_b = gz_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign m_xy   = (gx_r > gy_r) ? gx_r : gy_r;
  assign sq_bit = 64'd1 << {k_r, 1'b0};
  assign sq_try = res_r + sq_bit;
  assign r_eff  = (res_r[htn_pkg::ROOT_W-1:0] == '0) ? 32'd1 : res_r[htn_pkg::ROOT_W-1:0];

  always_comb begin
    case (ch_r)
      htn_pkg::CH_RED: begin
        ch_mag = gx_r[NB-1:0];
        ch_neg = req_r.dx_neg;
      end
      htn_pkg::CH_GREEN: begin
        ch_mag = gy_r[NB-1:0];
        ch_neg = req_r.dy_neg;
      end
      default: begin
        ch_mag = gz_r[NB-1:0];
        ch_neg = 1'b0;
      end
    endcase
  end

  assign r_ext  = htn_pkg::NUM_W'(r_eff);
  assign a_ext  = htn_pkg::NUM_W'(ch_mag);
  assign base   = (r_ext << 8) + r_ext;
  assign gain   = (a_ext << 8) - (a_ext << 1);
  assign num    = ch_neg ? (base - gain) : (base + gain);
  assign div_ge = (rem_r >= htn_pkg::NUM_W'(dsh_r));
  assign q_new  = {q_r[htn_pkg::CODE_W-2:0], div_ge};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htn_pkg::N_IDLE:  if (start) state_nxt = htn_pkg::N_MX;
      htn_pkg::N_MX:    state_nxt = htn_pkg::N_MY;
      htn_pkg::N_MY:    state_nxt = htn_pkg::N_GY;
      htn_pkg::N_GY:    state_nxt = htn_pkg::N_MAX;
      htn_pkg::N_MAX:   state_nxt = htn_pkg::N_SHIFT;
      htn_pkg::N_SHIFT: if (m_r[GW-1:NB] == '0) state_nxt = htn_pkg::N_SQX;
      htn_pkg::N_SQX:   state_nxt = htn_pkg::N_SQY;
      htn_pkg::N_SQY:   state_nxt = htn_pkg::N_SQZ;
      htn_pkg::N_SQZ:   state_nxt = htn_pkg::N_SUM;
      htn_pkg::N_SUM:   state_nxt = htn_pkg::N_SQRT;
      htn_pkg::N_SQRT:  if (k_r == 5'd0) state_nxt = htn_pkg::N_LOAD;
      htn_pkg::N_LOAD:  state_nxt = htn_pkg::N_DIV;
      htn_pkg::N_DIV: begin
        if (cnt_r == 3'd0) begin
          state_nxt = (ch_r == htn_pkg::CH_BLUE) ? htn_pkg::N_DONE : htn_pkg::N_LOAD;
        end
      end
      htn_pkg::N_DONE:  state_nxt = htn_pkg::N_IDLE;
      default: state_nxt = htn_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= htn_pkg::N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    case (state_r)
      htn_pkg::N_IDLE: begin
        req_r <= req;
        ch_r  <= htn_pkg::CH_RED;
      end
      htn_pkg::N_MY: gx_r <= prod_r[GW-1:0];
      htn_pkg::N_GY: begin
        gy_r <= prod_r[GW-1:0];
        gz_r <= GZ_INIT;
      end
      htn_pkg::N_MAX: m_r <= (m_xy > gz_r) ? m_xy : gz_r;
      htn_pkg::N_SHIFT: begin
        if (m_r[GW-1:NB] != '0) begin
          m_r  <= m_r >> 1;
          gx_r <= gx_r >> 1;
          gy_r <= gy_r >> 1;
          gz_r <= gz_r >> 1;
        end
      end
      htn_pkg::N_SQY: sum_r <= prod_r;
      htn_pkg::N_SQZ: sum_r <= sum_r + prod_r;
      htn_pkg::N_SUM: begin
        sum_r <= sum_r + prod_r;
        res_r <= '0;
        k_r   <= 5'd31;
      end
      htn_pkg::N_SQRT: begin
        if (sum_r >= sq_try) begin
          sum_r <= sum_r - sq_try;
          res_r <= (res_r >> 1) + sq_bit;
        end else begin
          res_r <= res_r >> 1;
        end
        k_r <= k_r - 5'd1;
      end
      htn_pkg::N_LOAD: begin
        rem_r <= num;
        dsh_r <= {r_eff, 8'd0};
        cnt_r <= 3'd7;
      end
      htn_pkg::N_DIV: begin
        if (div_ge) rem_r <= rem_r - htn_pkg::NUM_W'(dsh_r);
        q_r   <= q_new;
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          case (ch_r)
            htn_pkg::CH_RED:   red_r   <= q_new;
            htn_pkg::CH_GREEN: green_r <= q_new;
            default:           blue_r  <= q_new;
          endcase
          ch_r <= ch_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign done  = (state_r == htn_pkg::N_DONE);
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

[src/heightmap_to_normal_map_top.sv]
// ----------------------------------------------------------------------------
// Height map to normal map: top level
// Streams 16-bit height samples in raster order and emits encoded normals.
// ----------------------------------------------------------------------------
// Input items carry a height sample or a flush step plus the dx scale of the
// row being emitted. Result items carry red, green, blue and the end of row
// and end of image marks. Both channels use valid and stall; configuration
// is written through cfg_valid, cfg_index and cfg_data, and cfg_ready is
// always high. Width writes restart the image position.
// An item that gives no result is taken while in_stall stays low. An item
// that gives a result keeps in_stall high through three row store reads,
// the normalizing shift (one bit per cycle), a 32-step square root and
// three 8-step divisions, all on one shared datapath.
// A finished result sits in the output register while the next item is
// taken; if it is still stalled when the next result is ready, the block
// waits with in_stall high. Synchronous reset clears the position and the
// output valid and resets the configuration; the row store is not cleared.
// ----------------------------------------------------------------------------
module heightmap_to_normal_map_top #(
  parameter int MAX_WIDTH       = 4096,
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  htn_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output htn_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htn_pkg::SCALE_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(2 * MAX_WIDTH);

  htn_pkg::top_state_t state_r, state_nxt;

  logic [htn_pkg::IMG_W_W-1:0]  img_w_r;
  logic                         swap_r;
  logic [htn_pkg::SCALE_W-1:0]  vscale_r;
  logic [CW-1:0]                col_r, col_nxt, row_r, row_nxt;
  logic                         flushing_r, flushing_nxt;

  logic [htn_pkg::SAMPLE_W-1:0] mem [0:2*MAX_WIDTH-1];
  logic [htn_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]                rd_addr;

  logic [AW-1:0]                addr_a_r, addr_b_r, addr_c_r;
  logic                         is_flush_r, eor_r, eoi_r;
  logic [htn_pkg::SAMPLE_W-1:0] s_r, a_r, b_r;
  logic [htn_pkg::SCALE_W-1:0]  sx_r;
  logic                         out_valid_r;
  htn_pkg::out_t                out_data_r;

  logic [31:0]                  w32;
  logic [WW-1:0]                w, rows, xw, xp1, xb;
  logic [WW:0]                  xc, xc2;
  logic                         last, acc, emit, wr_en, width_wr, slot_free;
  logic [AW-1:0]                bank_off, other_off, rd_base, wr_addr;
  logic [htn_pkg::SAMPLE_W-1:0] s_in, c_val;
  logic [htn_pkg::SAMPLE_W:0]   d1, d2;
  htn_pkg::norm_req_t           req;
  logic                         norm_start, norm_done;
  logic [htn_pkg::CODE_W-1:0]   n_red, n_green, n_blue;

  assign w32 = (img_w_r < 13'd2) ? 32'd2 :
               ((32'(img_w_r) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(img_w_r));
  assign w    = w32[WW-1:0];
  assign rows = w >> 1;
  assign xw   = (WW'(col_r) >= w) ? '0 : WW'(col_r);
  assign xp1  = xw + 1'b1;
  assign last = (xp1 == w);
  assign xb   = last ? '0 : xp1;
  assign xc   = (WW+1)'(rows) + (WW+1)'(xw);
  assign xc2  = (xc >= (WW+1)'(w)) ? (xc - (WW+1)'(w)) : xc;

  assign bank_off  = row_r[0] ? AW'(MAX_WIDTH) : '0;
  assign other_off = row_r[0] ? '0 : AW'(MAX_WIDTH);
  assign rd_base   = in_data.action ? bank_off : other_off;
  assign wr_addr   = bank_off + AW'(xw);

  assign s_in = swap_r ? {in_data.sample[7:0], in_data.sample[15:8]} : in_data.sample;

  assign acc      = in_valid && (state_r == htn_pkg::T_IDLE);
  assign width_wr = cfg_valid && (cfg_index == htn_pkg::CFG_IMAGE_WIDTH);
  assign emit     = in_data.action ? flushing_r : (!flushing_r && (row_r != '0));
  assign wr_en    = acc && !in_data.action && !flushing_r;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    flushing_nxt = flushing_r;
    if (width_wr) begin
      col_nxt      = '0;
      row_nxt      = '0;
      flushing_nxt = 1'b0;
    end else if (acc && in_data.action && flushing_r) begin
      if (last) begin
        col_nxt      = '0;
        row_nxt      = '0;
        flushing_nxt = 1'b0;
      end else begin
        col_nxt = CW'(xp1);
      end
    end else if (wr_en) begin
      if (last) begin
        col_nxt = '0;
        if ((WW'(row_r) + 1'b1) >= rows) flushing_nxt = 1'b1;
        else row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = CW'(xp1);
      end
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign c_val     = is_flush_r ? rd_data_r : s_r;
  assign d1        = {1'b0, a_r} - {1'b0, b_r};
  assign d2        = {1'b0, a_r} - {1'b0, c_val};

  always_comb begin
    req.dx_neg  = d1[htn_pkg::SAMPLE_W];
    req.dx_mag  = d1[htn_pkg::SAMPLE_W] ? (~d1[htn_pkg::SAMPLE_W-1:0] + 1'b1)
                                        : d1[htn_pkg::SAMPLE_W-1:0];
    req.dy_neg  = d2[htn_pkg::SAMPLE_W];
    req.dy_mag  = d2[htn_pkg::SAMPLE_W] ? (~d2[htn_pkg::SAMPLE_W-1:0] + 1'b1)
                                        : d2[htn_pkg::SAMPLE_W-1:0];
    req.x_scale = sx_r;
  end

  always_comb begin
    state_nxt  = state_r;
    rd_addr    = addr_a_r;
    norm_start = 1'b0;
    case (state_r)
      htn_pkg::T_IDLE:  if (acc && emit) state_nxt = htn_pkg::T_RD_A;
      htn_pkg::T_RD_A:  state_nxt = htn_pkg::T_RD_B;
      htn_pkg::T_RD_B: begin
        rd_addr   = addr_b_r;
        state_nxt = htn_pkg::T_RD_C;
      end
      htn_pkg::T_RD_C: begin
        rd_addr   = addr_c_r;
        state_nxt = htn_pkg::T_START;
      end
      htn_pkg::T_START: begin
        norm_start = 1'b1;
        state_nxt  = htn_pkg::T_CALC;
      end
      htn_pkg::T_CALC:  if (norm_done) state_nxt = htn_pkg::T_PUSH;
      htn_pkg::T_PUSH:  if (slot_free) state_nxt = htn_pkg::T_IDLE;
      default: state_nxt = htn_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htn_pkg::T_IDLE;
      img_w_r     <= htn_pkg::IMAGE_WIDTH_RESET;
      swap_r      <= 1'b0;
      vscale_r    <= htn_pkg::VERTICAL_SCALE_RESET;
      col_r       <= '0;
      row_r       <= '0;
      flushing_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      flushing_r <= flushing_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          htn_pkg::CFG_IMAGE_WIDTH:    img_w_r  <= cfg_data[htn_pkg::IMG_W_W-1:0];
          htn_pkg::CFG_BYTE_SWAP:      swap_r   <= cfg_data[0];
          htn_pkg::CFG_VERTICAL_SCALE: vscale_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == htn_pkg::T_PUSH && slot_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= s_in;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      addr_a_r   <= rd_base + AW'(xw);
      addr_b_r   <= rd_base + AW'(xb);
      addr_c_r   <= rd_base + AW'(xc2);
      is_flush_r <= in_data.action;
      eor_r      <= last;
      eoi_r      <= in_data.action && last;
      s_r        <= s_in;
      sx_r       <= in_data.row_x_scale;
    end
    if (state_r == htn_pkg::T_RD_B) a_r <= rd_data_r;
    if (state_r == htn_pkg::T_RD_C) b_r <= rd_data_r;
    if (state_r == htn_pkg::T_PUSH && slot_free) begin
      out_data_r.red          <= n_red;
      out_data_r.green        <= n_green;
      out_data_r.blue         <= n_blue;
      out_data_r.end_of_row   <= eor_r;
      out_data_r.end_of_image <= eoi_r;
    end
  end

  htn_norm #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .req    (req),
    .vscale (vscale_r),
    .done   (norm_done),
    .red    (n_red),
    .green  (n_green),
    .blue   (n_blue)
  );

  assign in_stall  = (state_r != htn_pkg::T_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

[src/htn_checker.sv]
// ----------------------------------------------------------------------------
// Height map to normal map: port checker
// Watches the top-level ports over time and flags illegal sequences.
// ----------------------------------------------------------------------------
`include "heightmap_to_normal_map_top_defines.svh"

module htn_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input htn_pkg::out_t out_data
);

  `HTN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped while stalled")
  `HTN_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `HTN_ASSERT_NEXT(a_no_fast_result, in_valid && !in_stall, !$rose(out_valid), "result too soon")
  `HTN_ASSERT_SAME(a_push_busy, $rose(out_valid), $past(in_stall), "result without busy phase")
  `HTN_ASSERT_SAME(a_eoi_eor, out_valid && out_data.end_of_image, out_data.end_of_row, "image end off row end")

endmodule

bind heightmap_to_normal_map_top htn_checker u_htn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
